// ===== sv/gsg_pkg.sv =====
// Shared types and constants for the serial gamepad sender.
`timescale 1ns / 1ps

package gsg_pkg;

    localparam int MAX_PADS_DEF = 2;

    localparam int FRAME_BITS = 36;
    localparam int POS_W      = 7;
    localparam int CHUNKS     = 5;
    localparam int CHUNK_BITS = 5;
    localparam int CHUNK_BASE = 7;
    localparam int CHUNK_STEP = 6;
    localparam int DATA_W     = CHUNKS * CHUNK_BITS;

    localparam logic [FRAME_BITS-1:0] SYNC_MASK  = 36'h04104107F;
    localparam logic [FRAME_BITS-1:0] SYNC_VALUE = 36'h041041040;

    localparam logic signed [15:0] DPAD_LIMIT = 16'sd16384;

    localparam logic [7:0] PORT_IDLE   = 8'hf0;
    localparam logic [7:0] PORT_ABSENT = 8'hff;

    localparam logic [1:0] PAD_COUNT_RST = 2'd2;

    // APB map: one register per 32-bit word
    localparam int PADDR_W = 3;
    localparam logic REG_PAD_COUNT = 1'b0;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

endpackage

// ===== sv/gsg_frame.sv =====
// Builds one pad's 36-bit frame: d-pad thresholds, buttons, chunking, sync bits.
`timescale 1ns / 1ps

module gsg_frame (
    input  logic                         i_enable,
    input  logic [11:0]                  i_buttons,
    input  logic signed [15:0]           i_x,
    input  logic signed [15:0]           i_y,
    output logic [gsg_pkg::FRAME_BITS-1:0] o_frame
);

    logic [gsg_pkg::DATA_W-1:0]     w_data;
    logic [gsg_pkg::FRAME_BITS-1:0] w_raw;

    always_comb begin
        w_data       = '0;
        w_data[1]    = (i_y < -gsg_pkg::DPAD_LIMIT);
        w_data[2]    = !w_data[1] && (i_y > gsg_pkg::DPAD_LIMIT);
        w_data[3]    = (i_x < -gsg_pkg::DPAD_LIMIT);
        w_data[4]    = !w_data[3] && (i_x > gsg_pkg::DPAD_LIMIT);
        w_data[16:5] = i_buttons;
    end

    // chunk k lands at frame bit 7+6k; the gap bits carry sync
    always_comb begin
        w_raw = '0;
        for (int k = 0; k < gsg_pkg::CHUNKS; k++) begin
            w_raw[gsg_pkg::CHUNK_BASE + gsg_pkg::CHUNK_STEP*k +: gsg_pkg::CHUNK_BITS] =
                w_data[gsg_pkg::CHUNK_BITS*k +: gsg_pkg::CHUNK_BITS];
        end
    end

    assign o_frame = i_enable
                   ? ((w_raw & ~gsg_pkg::SYNC_MASK) | gsg_pkg::SYNC_VALUE)
                   : '0;

endmodule

// ===== sv/gsg_outbuf.sv =====
// Two-entry output buffer: result register plus skid entry for the port byte.
`timescale 1ns / 1ps

module gsg_outbuf (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data
);

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_skid_valid;
    logic [7:0] r_skid_data;
    logic       w_pop;

    assign w_pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // upstream is stalled while the skid entry is held
            if (w_pop) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= i_data;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== sv/gameport_serial_gamepad_sender_top.sv =====
// A read item's port byte is registered into the output or skid entry on acceptance.
// One item per cycle unless stalled; start and tick items update state at acceptance.
// Input stall rises only while both output entries hold undelivered bytes.
// Reset: idle, clock low, bit position 0, frames latched on next start, pad_count = 2.
// The pad_count register takes pwdata[1:0] from the APB port and reads back as written.
`timescale 1ns / 1ps

module gameport_serial_gamepad_sender_top #(
    parameter int MAX_PADS = gsg_pkg::MAX_PADS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsg_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_port_present,
    input  logic                         i_pad0_mapped,
    input  logic [11:0]                  i_pad0_buttons,
    input  logic signed [15:0]           i_pad0_x,
    input  logic signed [15:0]           i_pad0_y,
    input  logic                         i_pad1_mapped,
    input  logic [11:0]                  i_pad1_buttons,
    input  logic signed [15:0]           i_pad1_x,
    input  logic signed [15:0]           i_pad1_y,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_port_byte
);

    localparam int LIMIT_W = gsg_pkg::POS_W + 1;

    logic [1:0]                         r_pad_count;
    logic                               r_sending;
    logic                               r_half_clock;
    logic [gsg_pkg::POS_W-1:0]          r_bit_pos;
    gsg_pkg::t_frame                    r_frames [MAX_PADS];

    logic                               n_sending;
    logic                               n_half_clock;
    logic [gsg_pkg::POS_W-1:0]          n_bit_pos;

    logic                               w_accept;
    logic                               w_cfg_wr;
    gsg_pkg::t_opcode                   w_op;
    logic [1:0]                         w_n;
    logic                               w_start;
    logic [gsg_pkg::POS_W-1:0]          w_pos_inc;
    logic [LIMIT_W-1:0]                 w_limit;
    logic [1:0]                         w_pad;
    logic [gsg_pkg::POS_W-1:0]          w_bit;
    logic                               w_dbit;
    logic [7:0]                         w_read_byte;
    logic                               w_push;
    logic                               w_full;

    logic                               w_mapped  [2];
    logic [11:0]                        w_buttons [2];
    logic signed [15:0]                 w_x       [2];
    logic signed [15:0]                 w_y       [2];
    gsg_pkg::t_frame                    w_frame   [MAX_PADS];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == gsg_pkg::REG_PAD_COUNT);
    assign prdata   = (paddr[2] == gsg_pkg::REG_PAD_COUNT) ? {30'd0, r_pad_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_count <= gsg_pkg::PAD_COUNT_RST;
        end else if (w_cfg_wr) begin
            r_pad_count <= pwdata[1:0];
        end
    end

    // active pads: 0 acts as 1, anything above MAX_PADS acts as MAX_PADS
    always_comb begin
        if (r_pad_count == 2'd0) begin
            w_n = 2'd1;
        end else if (32'(r_pad_count) > MAX_PADS) begin
            w_n = 2'(MAX_PADS);
        end else begin
            w_n = r_pad_count;
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_op     = gsg_pkg::t_opcode'(i_opcode);
    assign w_start  = w_accept && (w_op == gsg_pkg::OP_START) && i_port_present && !r_sending;

    // frame builders, one per pad
    assign w_mapped[0]  = i_pad0_mapped;
    assign w_mapped[1]  = i_pad1_mapped;
    assign w_buttons[0] = i_pad0_buttons;
    assign w_buttons[1] = i_pad1_buttons;
    assign w_x[0]       = i_pad0_x;
    assign w_x[1]       = i_pad1_x;
    assign w_y[0]       = i_pad0_y;
    assign w_y[1]       = i_pad1_y;

    for (genvar p = 0; p < MAX_PADS; p++) begin : g_pad
        gsg_frame u_frame (
            .i_enable  (w_mapped[p] && (32'(w_n) > p)),
            .i_buttons (w_buttons[p]),
            .i_x       (w_x[p]),
            .i_y       (w_y[p]),
            .o_frame   (w_frame[p])
        );

        always_ff @(posedge i_clk) begin
            if (w_start) begin
                r_frames[p] <= w_frame[p];
            end
        end
    end

    // transfer sequencing
    assign w_pos_inc = r_bit_pos + 1'b1;
    assign w_limit   = LIMIT_W'(w_n) * LIMIT_W'(gsg_pkg::FRAME_BITS);

    always_comb begin
        n_sending    = r_sending;
        n_half_clock = r_half_clock;
        n_bit_pos    = r_bit_pos;
        if (w_accept) begin
            case (w_op)
                gsg_pkg::OP_START: begin
                    if (w_start) begin
                        n_sending    = 1'b1;
                        n_half_clock = 1'b0;
                        n_bit_pos    = '0;
                    end
                end
                gsg_pkg::OP_TICK: begin
                    if (r_sending) begin
                        n_half_clock = !r_half_clock;
                        if (!r_half_clock) begin
                            n_bit_pos = w_pos_inc;
                        end
                        if (LIMIT_W'(n_bit_pos) >= w_limit) begin
                            n_sending = 1'b0;
                            n_bit_pos = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending    <= 1'b0;
            r_half_clock <= 1'b0;
            r_bit_pos    <= '0;
        end else begin
            r_sending    <= n_sending;
            r_half_clock <= n_half_clock;
            r_bit_pos    <= n_bit_pos;
        end
    end

    // read path: split position into pad index and bit within the frame
    always_comb begin
        if (r_bit_pos >= gsg_pkg::POS_W'(2 * gsg_pkg::FRAME_BITS)) begin
            w_pad = 2'd2;
            w_bit = r_bit_pos - gsg_pkg::POS_W'(2 * gsg_pkg::FRAME_BITS);
        end else if (r_bit_pos >= gsg_pkg::POS_W'(gsg_pkg::FRAME_BITS)) begin
            w_pad = 2'd1;
            w_bit = r_bit_pos - gsg_pkg::POS_W'(gsg_pkg::FRAME_BITS);
        end else begin
            w_pad = 2'd0;
            w_bit = r_bit_pos;
        end
    end

    always_comb begin
        w_dbit      = 1'b0;
        w_read_byte = gsg_pkg::PORT_IDLE;
        if (!i_port_present) begin
            w_read_byte = gsg_pkg::PORT_ABSENT;
        end else if (r_sending) begin
            for (int p = 0; p < MAX_PADS; p++) begin
                if ((32'(w_pad) == p) && (w_pad < w_n)) begin
                    w_dbit = (w_bit < gsg_pkg::POS_W'(gsg_pkg::FRAME_BITS))
                           ? r_frames[p][w_bit[5:0]] : 1'b0;
                    if (!r_half_clock) begin
                        w_read_byte[4 + 2*p] = 1'b0;
                    end
                    if (w_dbit) begin
                        w_read_byte[5 + 2*p] = 1'b0;
                    end
                end
            end
        end else begin
            w_read_byte = {~i_pad0_buttons[3:0], 4'd0};
        end
    end

    assign w_push = w_accept && (w_op == gsg_pkg::OP_READ);

    gsg_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_read_byte),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_port_byte)
    );

    assign o_in_stall = w_full;

endmodule

// ===== bench/gameport_serial_gamepad_sender_top_tb.sv =====
// Self-checking testbench for the serial gamepad sender: directed and random port traffic.
`timescale 1ns / 1ps

module gameport_serial_gamepad_sender_top_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam logic [gsg_pkg::PADDR_W-1:0] ADDR_PAD_COUNT =
        gsg_pkg::PADDR_W'(4 * gsg_pkg::REG_PAD_COUNT);
    localparam logic [gsg_pkg::PADDR_W-1:0] ADDR_UNMAPPED  =
        gsg_pkg::PADDR_W'(ADDR_PAD_COUNT + 4);

    typedef struct {
        logic [1:0]         op;
        logic               present;
        logic               pad0_on;
        logic [11:0]        pad0_btn;
        logic signed [15:0] pad0_x;
        logic signed [15:0] pad0_y;
        logic               pad1_on;
        logic [11:0]        pad1_btn;
        logic signed [15:0] pad1_x;
        logic signed [15:0] pad1_y;
    } t_pad_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [gsg_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid;
    logic o_in_stall;
    logic [1:0] i_opcode;
    logic i_port_present;
    logic i_pad0_mapped;
    logic [11:0] i_pad0_buttons;
    logic signed [15:0] i_pad0_x, i_pad0_y;
    logic i_pad1_mapped;
    logic [11:0] i_pad1_buttons;
    logic signed [15:0] i_pad1_x, i_pad1_y;
    logic o_out_valid;
    logic i_out_stall;
    logic [7:0] o_port_byte;

    // predicted sender state
    logic [1:0]      pad_cnt;
    bit              xfer_on;
    bit              clk_high;
    logic [6:0]      bit_pos;
    gsg_pkg::t_frame latched_frame [2];

    logic [7:0] port_byte_q [$];
    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    bit item_took_effect;

    gameport_serial_gamepad_sender_top DUT (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    function automatic void note_failure(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    endfunction

    always @(posedge i_clk) begin : check_port_byte
        logic [7:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (port_byte_q.size() == 0) begin
                note_failure("port byte with none pending", 'x, 32'(o_port_byte));
            end else begin
                want = port_byte_q.pop_front();
                if (o_port_byte !== want)
                    note_failure("port byte", 32'(want), 32'(o_port_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned live_pads();
        if (pad_cnt == 2'd0)
            return 1;
        if (pad_cnt > gsg_pkg::MAX_PADS_DEF)
            return gsg_pkg::MAX_PADS_DEF;
        return 32'(pad_cnt);
    endfunction

    function automatic gsg_pkg::t_frame pack_frame(input logic [11:0] btn,
                                                   input logic signed [15:0] ax,
                                                   input logic signed [15:0] ay);
        logic [gsg_pkg::DATA_W-1:0] word;
        gsg_pkg::t_frame f;
        int xv, yv, lim, k;
        xv = ax;
        yv = ay;
        lim = gsg_pkg::DPAD_LIMIT;
        word = '0;
        if (xv < -lim)
            word[3] = 1'b1;
        else if (xv > lim)
            word[4] = 1'b1;
        if (yv < -lim)
            word[1] = 1'b1;
        else if (yv > lim)
            word[2] = 1'b1;
        word[16:5] = btn;
        f = '0;
        for (k = 0; k < gsg_pkg::CHUNKS; k++)
            f[gsg_pkg::CHUNK_BASE + gsg_pkg::CHUNK_STEP * k +: gsg_pkg::CHUNK_BITS] =
                word[gsg_pkg::CHUNK_BITS * k +: gsg_pkg::CHUNK_BITS];
        return (f & ~gsg_pkg::SYNC_MASK) | gsg_pkg::SYNC_VALUE;
    endfunction

    // advance the predicted state by one accepted item; 0 when the item is ignored
    function automatic bit apply_item(input t_pad_item it);
        int unsigned n, pad, fbit;
        logic [7:0] b;
        n = live_pads();
        case (it.op)
            gsg_pkg::OP_START: begin
                if (!it.present || xfer_on)
                    return 1'b0;
                xfer_on = 1'b1;
                clk_high = 1'b0;
                bit_pos = '0;
                latched_frame[0] = '0;
                latched_frame[1] = '0;
                if (it.pad0_on)
                    latched_frame[0] = pack_frame(it.pad0_btn, it.pad0_x, it.pad0_y);
                if (n >= 2 && it.pad1_on)
                    latched_frame[1] = pack_frame(it.pad1_btn, it.pad1_x, it.pad1_y);
                return 1'b1;
            end
            gsg_pkg::OP_TICK: begin
                if (!xfer_on)
                    return 1'b0;
                clk_high = !clk_high;
                if (clk_high)
                    bit_pos = bit_pos + 7'd1;
                if (bit_pos >= n * gsg_pkg::FRAME_BITS) begin
                    xfer_on = 1'b0;
                    bit_pos = '0;
                end
                return 1'b1;
            end
            gsg_pkg::OP_READ: begin
                b = gsg_pkg::PORT_IDLE;
                if (!it.present) begin
                    b = gsg_pkg::PORT_ABSENT;
                end else if (xfer_on) begin
                    pad = bit_pos / gsg_pkg::FRAME_BITS;
                    fbit = bit_pos % gsg_pkg::FRAME_BITS;
                    if (pad < n) begin
                        if (!clk_high)
                            b[4 + 2 * pad] = 1'b0;
                        if (latched_frame[pad][fbit])
                            b[5 + 2 * pad] = 1'b0;
                    end
                end else begin
                    b[7:4] = ~it.pad0_btn[3:0];
                end
                port_byte_q.push_back(b);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd16385;
            3: return -16'sd16384;
            4: return -16'sd16383;
            5: return 16'sd16383;
            6: return 16'sd16384;
            7: return 16'sd16385;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_pad_item random_item(input logic [1:0] op);
        t_pad_item it;
        it.op = op;
        it.present = ($urandom_range(19) != 0);
        it.pad0_on = ($urandom_range(7) != 0);
        it.pad0_btn = 12'($urandom_range(4095));
        it.pad0_x = random_axis();
        it.pad0_y = random_axis();
        it.pad1_on = ($urandom_range(7) != 0);
        it.pad1_btn = 12'($urandom_range(4095));
        it.pad1_x = random_axis();
        it.pad1_y = random_axis();
        return it;
    endfunction

    task automatic drive_payload(input t_pad_item it);
        i_opcode <= it.op;
        i_port_present <= it.present;
        i_pad0_mapped <= it.pad0_on;
        i_pad0_buttons <= it.pad0_btn;
        i_pad0_x <= it.pad0_x;
        i_pad0_y <= it.pad0_y;
        i_pad1_mapped <= it.pad1_on;
        i_pad1_buttons <= it.pad1_btn;
        i_pad1_x <= it.pad1_x;
        i_pad1_y <= it.pad1_y;
    endtask

    // valid stays high after acceptance so back-to-back items are driven without dropping valid
    task automatic send_item(input t_pad_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        drive_payload(it);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        item_took_effect = apply_item(it);
    endtask

    task automatic drain_port_bytes();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (port_byte_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [gsg_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
        drain_port_bytes();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_PAD_COUNT)
            pad_cnt = data[1:0];
        // read back in the same select
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_PAD_COUNT && prdata[1:0] !== pad_cnt)
            note_failure("pad_count readback", 32'(pad_cnt), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_idle_port();
        t_pad_item it;
        it = random_item(gsg_pkg::OP_READ);
        it.present = 1'b1;
        it.pad0_btn = 12'h00f;
        send_item(it);
        it.pad0_btn = 12'hff5;
        send_item(it);
        it.pad0_btn = 12'h000;
        send_item(it);
        it.present = 1'b0;
        send_item(it);
        it = random_item(gsg_pkg::OP_TICK);
        send_item(it);
        it.op = OP_RSVD;
        send_item(it);
        it = random_item(gsg_pkg::OP_START);
        it.present = 1'b0;
        send_item(it);
        it = random_item(gsg_pkg::OP_READ);
        it.present = 1'b1;
        it.pad0_btn = 12'h00a;
        send_item(it);
    endtask

    task automatic test_frame_latch();
        t_pad_item it, rd, tk;
        it = random_item(gsg_pkg::OP_START);
        it.present = 1'b1;
        it.pad0_on = 1'b1;
        it.pad0_btn = 12'hfff;
        it.pad0_x = 16'sh8000;
        it.pad0_y = 16'sh7fff;
        it.pad1_on = 1'b1;
        it.pad1_btn = 12'h000;
        it.pad1_x = 16'sd16385;
        it.pad1_y = -16'sd16385;
        send_item(it);
        rd = random_item(gsg_pkg::OP_READ);
        rd.present = 1'b1;
        tk = random_item(gsg_pkg::OP_TICK);
        send_item(rd);
        // second start mid-transfer must not relatch
        it.pad0_btn = 12'h000;
        it.pad0_x = 16'sd0;
        send_item(it);
        repeat (3) begin
            send_item(tk);
            send_item(rd);
        end
    endtask

    task automatic test_count_change();
        t_pad_item it, rd, tk;
        rd = random_item(gsg_pkg::OP_READ);
        rd.present = 1'b1;
        tk = random_item(gsg_pkg::OP_TICK);
        while (bit_pos < 7'd40)
            send_item(tk);
        send_item(rd);
        // drop below the pad being sent: reads go blank, next tick ends it
        apb_write(ADDR_PAD_COUNT, 32'd1);
        send_item(rd);
        send_item(tk);
        send_item(rd);
        // raise mid-transfer: second frame was never latched
        it = random_item(gsg_pkg::OP_START);
        it.present = 1'b1;
        it.pad0_on = 1'b1;
        it.pad0_x = 16'sd16384;
        it.pad0_y = -16'sd16384;
        it.pad1_on = 1'b1;
        send_item(it);
        while (bit_pos < 7'd20)
            send_item(tk);
        apb_write(ADDR_PAD_COUNT, 32'd2);
        while (bit_pos < 7'd38)
            send_item(tk);
        send_item(rd);
        while (xfer_on)
            send_item(tk);
        send_item(rd);
        // count 0 acts as one pad; a write past the register map changes nothing
        apb_write(ADDR_PAD_COUNT, 32'd0);
        apb_write(ADDR_UNMAPPED, 32'd3);
        it.pad0_on = 1'b0;
        send_item(it);
        send_item(rd);
        while (xfer_on)
            send_item(tk);
        send_item(rd);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [1:0] count,
                             input int items);
        t_pad_item it;
        logic [1:0] op;
        int done, r;
        idle_pct = idle;
        stall_pct = stall;
        apb_write(ADDR_PAD_COUNT, {30'd0, count});
        done = 0;
        // reads scattered over the bits; a transfer may run on into the next phase
        while (done < items) begin
            r = $urandom_range(99);
            if (xfer_on)
                op = (r < 75) ? gsg_pkg::OP_TICK : (r < 95) ? gsg_pkg::OP_READ :
                     (r < 98) ? gsg_pkg::OP_START : OP_RSVD;
            else
                op = (r < 60) ? gsg_pkg::OP_START : (r < 85) ? gsg_pkg::OP_READ :
                     (r < 93) ? gsg_pkg::OP_TICK : OP_RSVD;
            it = random_item(op);
            send_item(it);
            if (item_took_effect)
                done++;
            if ($urandom_range(99) < 2)
                drain_port_bytes();
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 2'd2, 55);
        run_phase(81, 0, 2'd1, 55);
        run_phase(0, 81, 2'd0, 55);
        run_phase(18, 18, 2'd3, 55);
    endtask

    initial begin : main
        t_pad_item blank;
        blank = random_item(gsg_pkg::OP_READ);
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        drive_payload(blank);
        pad_cnt = gsg_pkg::PAD_COUNT_RST;
        xfer_on = 1'b0;
        clk_high = 1'b0;
        bit_pos = '0;
        latched_frame[0] = '0;
        latched_frame[1] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_port();
        test_frame_latch();
        test_count_change();
        test_random_traffic();
        drain_port_bytes();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gsg_pkg.sv
sv/gsg_frame.sv
sv/gsg_outbuf.sv
sv/gameport_serial_gamepad_sender_top.sv
bench/gameport_serial_gamepad_sender_top_tb.sv
